/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the time stretcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define OLATS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define OLATS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/olats_pkg.sv */
// Shared types, constants and the Hann coefficient function of the time stretcher.
package olats_pkg;

    // Fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int AHOP_W     = 9;
    localparam int SHOP_W     = 7;
    localparam int FLUSH_W    = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // Defaults of the top level parameters
    localparam int WINDOW_LEN_DEF       = 256;
    localparam int MAX_SYNTH_HOP_DEF    = 64;
    localparam int WINDOW_FRAC_BITS_DEF = 15;

    // Accumulator headroom above the coefficient fraction
    localparam int ACC_EXTRA = 21;

    // Register reset values and limits
    localparam logic [AHOP_W-1:0]  AHOP_RST  = 9'd64;
    localparam logic [SHOP_W-1:0]  SHOP_RST  = 7'd64;
    localparam logic [FLUSH_W-1:0] FLUSH_MAX = 9'h1FF;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    // Q30 constants for the coefficient table
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] TAYLOR_DEN [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210};

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PAD,
        S_WALK,
        S_DRAIN,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AHOP = 1'b0,
        CFG_SHOP = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_FLUSH  = 1'b1
    } t_mode;

    // Control travelling with one window entry into the multiply-add pipeline
    typedef struct packed {
        logic valid;
        logic use_acc;
    } t_mac_ctl;

    // Hann coefficient sin^2 from a Q30 angle on the folded half period
    function automatic logic [63:0] hann_coef(input logic [63:0] x, input int frac);
        logic [63:0] x2;
        logic [63:0] sum;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] w;
        logic [63:0] one_w;
        x2  = (x * x) >> 30;
        sum = x;
        mag = x;
        for (int k = 1; k <= 7; k++) begin
            mag = ((mag * x2) >> 30) / TAYLOR_DEN[k];
            if ((k % 2) == 1) begin
                sum = (mag > sum) ? 64'd0 : sum - mag;
            end else begin
                sum = sum + mag;
            end
        end
        if (sum > ONE_Q30) begin
            sum = ONE_Q30;
        end
        sq    = (sum * sum) >> 30;
        w     = (sq + (64'd1 << (29 - frac))) >> (30 - frac);
        one_w = 64'd1 << frac;
        if (w > one_w) begin
            w = one_w;
        end
        return w;
    endfunction

endpackage

/* rtl/olats_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module olats_ram #(
    parameter int WIDTH = olats_pkg::SAMPLE_W,
    parameter int DEPTH = olats_pkg::WINDOW_LEN_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry and read one entry into the registered read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/olats_hann_rom.sv */
// Hann window coefficient ROM with registered read, built at elaboration.
module olats_hann_rom #(
    parameter int WINDOW_LEN       = olats_pkg::WINDOW_LEN_DEF,
    parameter int WINDOW_FRAC_BITS = olats_pkg::WINDOW_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic [$clog2(WINDOW_LEN)-1:0] i_addr,
    output logic [WINDOW_FRAC_BITS:0]     o_coef
);
    import olats_pkg::*;

    logic [WINDOW_FRAC_BITS:0] tab_coef [WINDOW_LEN];
    logic [WINDOW_FRAC_BITS:0] r_coef;

    // Fold the angle about the half window and form sin^2 for each entry
    for (genvar n = 0; n < WINDOW_LEN; n++) begin : g_tab
        localparam int P = (n <= WINDOW_LEN / 2) ? n : WINDOW_LEN - n;
        localparam logic [63:0] ANG = PI_Q30 * 64'(P) / 64'(WINDOW_LEN);
        localparam logic [63:0] COEF = hann_coef(ANG, WINDOW_FRAC_BITS);
        assign tab_coef[n] = COEF[WINDOW_FRAC_BITS:0];
    end

    // Register the looked-up coefficient
    always_ff @(posedge i_clk) begin
        r_coef <= tab_coef[i_addr];
    end

    assign o_coef = r_coef;
endmodule

/* rtl/olats_mac.sv */
// Window multiply and saturating accumulate pipeline feeding the accumulator memory.
module olats_mac #(
    parameter int WINDOW_LEN       = olats_pkg::WINDOW_LEN_DEF,
    parameter int WINDOW_FRAC_BITS = olats_pkg::WINDOW_FRAC_BITS_DEF
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  olats_pkg::t_mac_ctl                                  i_ctl,
    input  logic [$clog2(WINDOW_LEN)-1:0]                        i_addr,
    input  logic signed [olats_pkg::SAMPLE_W-1:0]                i_sample,
    input  logic [WINDOW_FRAC_BITS:0]                            i_coef,
    input  logic signed [WINDOW_FRAC_BITS+olats_pkg::ACC_EXTRA-1:0] i_acc,
    output logic                                                 o_busy,
    output logic                                                 o_we,
    output logic [$clog2(WINDOW_LEN)-1:0]                        o_waddr,
    output logic [WINDOW_FRAC_BITS+olats_pkg::ACC_EXTRA-1:0]     o_wdata
);
    import olats_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW_LEN);
    localparam int ACC_W  = WINDOW_FRAC_BITS + ACC_EXTRA;
    localparam int PROD_W = SAMPLE_W + WINDOW_FRAC_BITS + 2;

    t_mac_ctl                  r_ctl;
    logic [IDX_W-1:0]          r_addr;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [ACC_W:0]     prod_ext;
    logic signed [ACC_W:0]     acc_ext;
    logic signed [ACC_W:0]     sum;
    logic signed [ACC_W-1:0]   sum_sat;

    // Multiply the sample by its coefficient
    assign n_prod = $signed(i_sample) * $signed({1'b0, i_coef});

    // Register product, shifted accumulator entry and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_addr <= i_addr;
        r_prod <= n_prod;
        r_acc  <= i_ctl.use_acc ? i_acc : '0;
    end

    // Add and saturate to the accumulator range
    always_comb begin
        prod_ext = (ACC_W+1)'(r_prod);
        acc_ext  = (ACC_W+1)'(r_acc);
        sum      = prod_ext + acc_ext;
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            sum_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sum_sat = sum[ACC_W-1:0];
        end
    end

    assign o_busy  = r_ctl.valid;
    assign o_we    = r_ctl.valid;
    assign o_waddr = r_addr;
    assign o_wdata = sum_sat;
endmodule

/* rtl/overlap_add_time_stretch.sv */
// A sample that completes no frame is stored with input left ready; a flush pads zeros
// up to the frame target. A frame walks all WINDOW_LEN entries, one a cycle, through the
// accumulator memory port, then the multiply-add pipeline drains, then synthesis_hop items
// are emitted, each read in S_EMIT_RD and loaded into the output register in S_EMIT_LD.
// Reset, and the end of a stream, run a clearing pass over all WINDOW_LEN entries of both
// memories in which no item is accepted; configuration writes are always taken.
module overlap_add_time_stretch #(
    parameter int WINDOW_LEN       = olats_pkg::WINDOW_LEN_DEF,
    parameter int MAX_SYNTH_HOP    = olats_pkg::MAX_SYNTH_HOP_DEF,
    parameter int WINDOW_FRAC_BITS = olats_pkg::WINDOW_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [olats_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [olats_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_mode,
    input  logic signed [olats_pkg::SAMPLE_W-1:0] i_sample_in,
    // Output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [olats_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                  o_frame_last,
    output logic                                  o_stream_done
);
    import olats_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_LEN);
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int ACC_W = WINDOW_FRAC_BITS + ACC_EXTRA;
    localparam int AW    = (AHOP_W > CNT_W) ? AHOP_W : CNT_W;
    localparam int FP_W  = FLUSH_W + AW;
    localparam int SMAX  = (MAX_SYNTH_HOP < WINDOW_LEN) ? MAX_SYNTH_HOP : WINDOW_LEN;
    localparam int Q_W   = ACC_W - WINDOW_FRAC_BITS + 1;

    // Configuration registers
    logic [AHOP_W-1:0] r_ahop;
    logic [SHOP_W-1:0] r_shop;

    // Control state
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_wp, n_wp;
    logic [IDX_W-1:0]  r_pin, n_pin;
    logic [IDX_W-1:0]  r_pacc, n_pacc;
    logic [IDX_W-1:0]  r_ap, n_ap;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [FLUSH_W-1:0] r_flush, n_flush;
    logic              r_first, n_first;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_lim, n_lim;
    logic [SHOP_W-1:0] r_slast, n_slast;
    t_mac_ctl          r_c1, n_c1;
    logic [IDX_W-1:0]  r_c1_addr;

    // Output register
    logic                       r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample, n_out_sample;
    logic                       r_out_last, n_out_last;
    logic                       r_out_done, n_out_done;

    // Derived hops and thresholds
    logic [AW-1:0]     ha_raw;
    logic [AW-1:0]     ha_eff;
    logic [SHOP_W-1:0] shop_nz;
    logic [SHOP_W-1:0] shop_eff;
    logic [CNT_W-1:0]  target;
    logic [CNT_W-1:0]  fill_inc;
    logic [FLUSH_W-1:0] flush_inc;
    logic [FP_W-1:0]   flush_prod;
    logic              done_c;
    logic [IDX_W:0]    ap_sum;
    logic [IDX_W-1:0]  ap_new;
    logic              emit_last;

    // Memory ports
    logic                   push;
    logic [SAMPLE_W-1:0]    push_data;
    logic                   clr_we;
    logic                   start_walk;
    logic                   in_acc;
    logic                   in_we;
    logic [IDX_W-1:0]       in_waddr;
    logic [SAMPLE_W-1:0]    in_rdata;
    logic                   acc_we;
    logic [IDX_W-1:0]       acc_waddr;
    logic [ACC_W-1:0]       acc_wdata;
    logic [ACC_W-1:0]       acc_rdata;
    logic [WINDOW_FRAC_BITS:0] coef;
    logic                   mac_busy;
    logic                   mac_we;
    logic [IDX_W-1:0]       mac_waddr;
    logic [ACC_W-1:0]       mac_wdata;

    // Output scaling
    logic signed [ACC_W:0]    acc_ext;
    logic signed [ACC_W:0]    bias;
    logic signed [ACC_W:0]    biased;
    logic signed [Q_W-1:0]    q_int;
    logic signed [SAMPLE_W-1:0] q_sat;

    function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(WINDOW_LEN - 1)) ? '0 : p + 1'b1;
    endfunction

    // Take configuration writes at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ahop <= AHOP_RST;
            r_shop <= SHOP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_AHOP: r_ahop <= i_cfg_data[AHOP_W-1:0];
                CFG_SHOP: r_shop <= i_cfg_data[SHOP_W-1:0];
                default:  r_ahop <= r_ahop;
            endcase
        end
    end

    // Clamp the hops into their working ranges
    always_comb begin
        ha_raw   = (r_ahop == '0) ? AW'(1) : AW'(r_ahop);
        ha_eff   = (ha_raw > AW'(WINDOW_LEN)) ? AW'(WINDOW_LEN) : ha_raw;
        shop_nz  = (r_shop == '0) ? SHOP_W'(1) : r_shop;
        shop_eff = (shop_nz > SHOP_W'(SMAX)) ? SHOP_W'(SMAX) : shop_nz;
        target   = r_first ? CNT_W'(ha_eff) : CNT_W'(WINDOW_LEN);
        fill_inc = r_fill + 1'b1;
        flush_inc  = (r_flush == FLUSH_MAX) ? r_flush : r_flush + 1'b1;
        flush_prod = FP_W'(flush_inc) * FP_W'(ha_eff);
        done_c     = flush_prod >= FP_W'(WINDOW_LEN);
        ap_sum     = (IDX_W+1)'(r_ap) + (IDX_W+1)'(shop_eff);
        ap_new     = (ap_sum >= (IDX_W+1)'(WINDOW_LEN))
                   ? IDX_W'(ap_sum - (IDX_W+1)'(WINDOW_LEN)) : IDX_W'(ap_sum);
        emit_last  = (r_cnt == CNT_W'(r_slast));
    end

    // Scale an accumulator entry to a sample: truncate toward zero, saturate
    always_comb begin
        acc_ext = (ACC_W+1)'($signed(acc_rdata));
        bias    = acc_rdata[ACC_W-1] ? (ACC_W+1)'((1 << WINDOW_FRAC_BITS) - 1) : '0;
        biased  = acc_ext + bias;
        q_int   = $signed(biased[ACC_W:WINDOW_FRAC_BITS]);
        if (q_int > SAMPLE_MAX) begin
            q_sat = SAMPLE_W'(SAMPLE_MAX);
        end else if (q_int < SAMPLE_MIN) begin
            q_sat = SAMPLE_W'(SAMPLE_MIN);
        end else begin
            q_sat = q_int[SAMPLE_W-1:0];
        end
    end

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_wp         = r_wp;
        n_pin        = r_pin;
        n_pacc       = r_pacc;
        n_ap         = r_ap;
        n_fill       = r_fill;
        n_flush      = r_flush;
        n_first      = r_first;
        n_done       = r_done;
        n_lim        = r_lim;
        n_slast      = r_slast;
        n_c1         = '0;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_sample = r_out_sample;
        n_out_last   = r_out_last;
        n_out_done   = r_out_done;
        push         = 1'b0;
        push_data    = '0;
        clr_we       = 1'b0;
        start_walk   = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                clr_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WINDOW_LEN - 1)) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                    n_wp    = '0;
                    n_ap    = '0;
                    n_fill  = '0;
                    n_flush = '0;
                    n_first = 1'b0;
                    n_done  = 1'b0;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_mode == MODE_SAMPLE) begin
                        push      = 1'b1;
                        push_data = i_sample_in;
                        if (fill_inc >= target) begin
                            start_walk = 1'b1;
                        end
                    end else begin
                        n_flush = flush_inc;
                        n_done  = done_c;
                        if (r_fill < target) begin
                            n_state = S_PAD;
                        end else begin
                            start_walk = 1'b1;
                        end
                    end
                end
            end
            S_PAD: begin
                // Pad one zero a cycle up to the frame target
                push = 1'b1;
                if (fill_inc >= target) begin
                    start_walk = 1'b1;
                end
            end
            S_WALK: begin
                n_c1.valid   = 1'b1;
                n_c1.use_acc = (r_cnt < r_lim);
                n_pin        = inc_wrap(r_pin);
                n_pacc       = inc_wrap(r_pacc);
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WINDOW_LEN - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_cnt = '0;
                if (!r_c1.valid && !mac_busy) begin
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                // Read the next result once the output register frees
                if (!r_out_valid || i_out_ready) begin
                    n_pacc  = inc_wrap(r_pacc);
                    n_state = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                n_out_valid  = 1'b1;
                n_out_sample = q_sat;
                n_out_last   = emit_last;
                n_out_done   = r_done && emit_last;
                if (emit_last) begin
                    n_cnt   = '0;
                    n_state = r_done ? S_CLEAR : S_IDLE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_cnt   = '0;
            end
        endcase

        // Advance the input write pointer on every stored sample
        if (push) begin
            n_wp   = inc_wrap(r_wp);
            n_fill = fill_inc;
        end

        // Start a frame: shift the accumulator base by the synthesis hop
        if (start_walk) begin
            n_state = S_WALK;
            n_cnt   = '0;
            n_fill  = '0;
            n_first = 1'b1;
            n_ap    = ap_new;
            n_pacc  = ap_new;
            n_pin   = n_wp;
            n_lim   = CNT_W'(WINDOW_LEN) - CNT_W'(shop_eff);
            n_slast = shop_eff - 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_wp        <= '0;
            r_pin       <= '0;
            r_pacc      <= '0;
            r_ap        <= '0;
            r_fill      <= '0;
            r_flush     <= '0;
            r_first     <= 1'b0;
            r_done      <= 1'b0;
            r_lim       <= '0;
            r_slast     <= '0;
            r_c1        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_wp        <= n_wp;
            r_pin       <= n_pin;
            r_pacc      <= n_pacc;
            r_ap        <= n_ap;
            r_fill      <= n_fill;
            r_flush     <= n_flush;
            r_first     <= n_first;
            r_done      <= n_done;
            r_lim       <= n_lim;
            r_slast     <= n_slast;
            r_c1        <= n_c1;
            r_out_valid <= n_out_valid;
        end
        r_c1_addr    <= r_pacc;
        r_out_sample <= n_out_sample;
        r_out_last   <= n_out_last;
        r_out_done   <= n_out_done;
    end

    // Memory port selection
    assign in_we     = clr_we || push;
    assign in_waddr  = clr_we ? r_cnt[IDX_W-1:0] : r_wp;
    assign acc_we    = clr_we || mac_we;
    assign acc_waddr = clr_we ? r_cnt[IDX_W-1:0] : mac_waddr;
    assign acc_wdata = clr_we ? '0 : mac_wdata;

    olats_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_LEN)
    ) u_in_ram (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (in_waddr),
        .i_wdata (push_data),
        .i_raddr (r_pin),
        .o_rdata (in_rdata)
    );

    olats_ram #(
        .WIDTH (ACC_W),
        .DEPTH (WINDOW_LEN)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_raddr (r_pacc),
        .o_rdata (acc_rdata)
    );

    olats_hann_rom #(
        .WINDOW_LEN       (WINDOW_LEN),
        .WINDOW_FRAC_BITS (WINDOW_FRAC_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_cnt[IDX_W-1:0]),
        .o_coef (coef)
    );

    olats_mac #(
        .WINDOW_LEN       (WINDOW_LEN),
        .WINDOW_FRAC_BITS (WINDOW_FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_c1),
        .i_addr   (r_c1_addr),
        .i_sample ($signed(in_rdata)),
        .i_coef   (coef),
        .i_acc    ($signed(acc_rdata)),
        .o_busy   (mac_busy),
        .o_we     (mac_we),
        .o_waddr  (mac_waddr),
        .o_wdata  (mac_wdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_sample_out  = r_out_sample;
    assign o_frame_last  = r_out_last;
    assign o_stream_done = r_out_done;
endmodule

/* rtl/olats_checker.sv */
// Port-level checks of the time stretcher, bound to the top level.
`include "assert_macros.svh"

module olats_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_mode,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_sample_out,
    input logic        o_frame_last,
    input logic        o_stream_done
);
    // A stalled output item holds
    `OLATS_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_sample_out) && $stable(o_frame_last)), "output item changed while stalled")

    // The end of a stream falls on the last item of a frame
    `OLATS_ASSERT(a_done_last, (o_out_valid && o_stream_done) |-> o_frame_last, "stream done without frame last")

    // A flush item always starts a frame, so input is held off next cycle
    `OLATS_ASSERT(a_flush_busy, (i_in_valid && o_in_ready && i_mode) |=> !o_in_ready, "input ready after a flush item")

    // Reset drops the output and starts the clearing pass
    `OLATS_ASSERT_RST(a_rst_quiet, !i_rst_n |=> (!o_out_valid && !o_in_ready), "ports active after reset")
endmodule

bind overlap_add_time_stretch olats_checker u_olats_checker (.*);

/* dv/tb_overlap_add_time_stretch.sv */
// Testbench for the overlap-add time stretcher, checked against an in-bench Hann overlap-add model.
module tb_overlap_add_time_stretch;
    import olats_pkg::*;

    localparam int WIN      = WINDOW_LEN_DEF;
    localparam int MAX_SHOP = MAX_SYNTH_HOP_DEF;
    localparam int FRAC     = WINDOW_FRAC_BITS_DEF;
    localparam int ACC_W    = FRAC + ACC_EXTRA;
    localparam int N_DIR    = 25;
    localparam int N_RAND   = 445;
    // Covers the clearing pass at the end of a stream
    localparam int SETTLE   = 320;
    localparam int LIMIT    = 6_000_000;
    localparam longint unsigned HALF_TURN_Q30 = 64'd3373259426;
    localparam longint unsigned UNIT_Q30      = 64'd1 << 30;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       frame_last;
        logic                       stream_done;
    } t_out_sample;

    typedef struct {
        t_mode                      mode;
        logic signed [SAMPLE_W-1:0] smp;
        bit                         known;
        logic signed [SAMPLE_W-1:0] known_out;
    } t_dir_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = CFG_AHOP;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic                          i_mode = MODE_SAMPLE;
    logic signed [SAMPLE_W-1:0]    i_sample_in = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0]    o_sample_out;
    logic                          o_frame_last;
    logic                          o_stream_done;

    // Model state
    int unsigned                   hann_rom [WIN];
    logic signed [SAMPLE_W-1:0]    win_store [WIN];
    longint                        ola_acc [WIN];
    int                            fill_cnt;
    int                            flush_cnt;
    bit                            frame_started;
    logic [AHOP_W-1:0]             ahop_reg;
    logic [SHOP_W-1:0]             shop_reg;

    t_out_sample                   pending_samples [$];
    t_dir_row                      dir_items [N_DIR];
    int                            mismatch_cnt = 0;
    int                            cycle_cnt = 0;
    int                            stall_left = 0;
    bit                            tx_quiet = 1'b0;
    bit                            rx_quiet = 1'b0;

    overlap_add_time_stretch dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_sample_in   (i_sample_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sample_out  (o_sample_out),
        .o_frame_last  (o_frame_last),
        .o_stream_done (o_stream_done)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Abandon the run if it hangs
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Periodic Hann table: Q30 sine by Taylor series on the folded angle, squared, rounded
    function automatic void build_hann_rom();
        longint unsigned p, x, x2, sum, mag, sq, w;
        for (int n = 0; n < WIN; n++) begin
            p   = (n <= WIN / 2) ? n : WIN - n;
            x   = HALF_TURN_Q30 * p / WIN;
            x2  = (x * x) >> 30;
            sum = x;
            mag = x;
            for (int k = 1; k <= 7; k++) begin
                mag = ((mag * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    sum = (mag > sum) ? 0 : sum - mag;
                end else begin
                    sum = sum + mag;
                end
            end
            if (sum > UNIT_Q30) begin
                sum = UNIT_Q30;
            end
            sq = (sum * sum) >> 30;
            w  = (sq + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
            if (w > (64'd1 << FRAC)) begin
                w = 64'd1 << FRAC;
            end
            hann_rom[n] = int'(w);
        end
    endfunction

    function automatic void clear_stream();
        for (int i = 0; i < WIN; i++) begin
            win_store[i] = '0;
            ola_acc[i]   = 0;
        end
        fill_cnt      = 0;
        flush_cnt     = 0;
        frame_started = 1'b0;
    endfunction

    function automatic int ahop_eff();
        int h;
        h = int'(ahop_reg);
        if (h == 0) h = 1;
        if (h > WIN) h = WIN;
        return h;
    endfunction

    function automatic int shop_eff();
        int h;
        h = int'(shop_reg);
        if (h == 0) h = 1;
        if (h > MAX_SHOP) h = MAX_SHOP;
        if (h > WIN) h = WIN;
        return h;
    endfunction

    function automatic void shift_in(logic signed [SAMPLE_W-1:0] s);
        for (int i = 0; i < WIN - 1; i++) begin
            win_store[i] = win_store[i + 1];
        end
        win_store[WIN - 1] = s;
        fill_cnt++;
    endfunction

    // Window the store, overlap-add into the shifted accumulator, queue the head samples
    function automatic int add_frame(bit done);
        longint      acc_hi, acc_lo, v, q;
        int          sh;
        t_out_sample e;
        acc_hi = (longint'(1) <<< (ACC_W - 1)) - 1;
        acc_lo = -acc_hi - 1;
        sh     = shop_eff();
        for (int j = 0; j < WIN; j++) begin
            v = longint'(win_store[j]) * longint'(hann_rom[j]);
            if (j < WIN - sh) v += ola_acc[j + sh];
            if (v > acc_hi) v = acc_hi;
            if (v < acc_lo) v = acc_lo;
            ola_acc[j] = v;
        end
        for (int j = 0; j < sh; j++) begin
            q = ola_acc[j] / (longint'(1) <<< FRAC);
            if (q > SAMPLE_MAX) q = SAMPLE_MAX;
            if (q < SAMPLE_MIN) q = SAMPLE_MIN;
            e.sample_out  = q[SAMPLE_W-1:0];
            e.frame_last  = (j == sh - 1);
            e.stream_done = done && (j == sh - 1);
            pending_samples.push_back(e);
        end
        fill_cnt      = 0;
        frame_started = 1'b1;
        return sh;
    endfunction

    // Advance the model by one accepted item; return how many samples it queued
    function automatic int stretch_step(t_mode m, logic signed [SAMPLE_W-1:0] s);
        int target, ha, nres, n;
        bit done;
        n      = 0;
        target = frame_started ? ahop_eff() : WIN;
        if (m == MODE_SAMPLE) begin
            shift_in(s);
            if (fill_cnt >= target) n = add_frame(1'b0);
        end else begin
            ha   = ahop_eff();
            nres = (WIN + ha - 1) / ha;
            while (fill_cnt < target) shift_in('0);
            if (flush_cnt < int'(FLUSH_MAX)) flush_cnt++;
            done = flush_cnt >= nres;
            n    = add_frame(done);
            if (done) clear_stream();
        end
        return n;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        if (mismatch_cnt < 100) begin
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_cnt, what, got, want);
        end
        mismatch_cnt++;
    endtask

    // Compare each accepted output item with the oldest expectation
    always @(posedge i_clk) begin
        t_out_sample e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_samples.size() == 0) begin
                flag_mismatch("unexpected sample_out", o_sample_out, 0);
            end else begin
                e = pending_samples.pop_front();
                if (o_sample_out !== e.sample_out)
                    flag_mismatch("sample_out", o_sample_out, e.sample_out);
                if (o_frame_last !== e.frame_last)
                    flag_mismatch("frame_last", o_frame_last, e.frame_last);
                if (o_stream_done !== e.stream_done)
                    flag_mismatch("stream_done", o_stream_done, e.stream_done);
            end
        end
    end

    // Drop output ready in runs of random length, mostly short
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if (!rx_quiet && $urandom_range(0, 99) < 20) begin
            i_out_ready <= 1'b0;
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                      : $urandom_range(11, 39);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // Offer one item after a gap and hold it until taken; valid stays high on return
    task automatic send_item(t_mode m, logic signed [SAMPLE_W-1:0] s, int gap, output int n);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_mode      <= m;
        i_sample_in <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n = stretch_step(m, s);
    endtask

    // Hold the input until every expected sample is out and the block has settled
    task automatic drain_outputs();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_AHOP) begin
            ahop_reg = data[AHOP_W-1:0];
        end else begin
            shop_reg = data[SHOP_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(int style);
        case (style)
            1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2:       return SAMPLE_W'($urandom_range(0, 8) - 4);
            3:       return ($urandom_range(0, 9) != 0) ? 16'sh7FFF : 16'sh8000;
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        int                         n, sent, phase, plen, style, flush_pct, nres;
        bit                         close_stream;
        logic [AHOP_W-1:0]          ahop_new;
        logic [CFG_DATA_W-1:0]      shop_data;
        t_mode                      m;

        dir_items = '{
            // flush straight after reset, then with nothing pending
            '{MODE_FLUSH,  16'sh0000, 1'b1, 16'sh0000},
            '{MODE_FLUSH,  16'sh7FFF, 1'b1, 16'sh0000},
            // samples taken in while a flush is under way
            '{MODE_SAMPLE, 16'sh7FFF, 1'b0, 16'sh0000},
            '{MODE_SAMPLE, 16'sh8000, 1'b0, 16'sh0000},
            '{MODE_SAMPLE, 16'sh0001, 1'b0, 16'sh0000},
            '{MODE_SAMPLE, 16'shFFFF, 1'b0, 16'sh0000},
            '{MODE_FLUSH,  16'sh0000, 1'b0, 16'sh0000},
            // fourth flush at the default hop ends the stream
            '{MODE_FLUSH,  16'sh5A5A, 1'b0, 16'sh0000},
            // new stream, short of a full window
            '{MODE_SAMPLE, 16'sh7FFF, 1'b0, 16'sh0000},
            '{MODE_SAMPLE, 16'sh7FFF, 1'b0, 16'sh0000},
            '{MODE_SAMPLE, 16'sh8000, 1'b0, 16'sh0000},
            '{MODE_SAMPLE, 16'sh5555, 1'b0, 16'sh0000},
            '{MODE_SAMPLE, 16'shAAAA, 1'b0, 16'sh0000},
            '{MODE_SAMPLE, 16'sh0000, 1'b0, 16'sh0000},
            '{MODE_SAMPLE, 16'sh7FFF, 1'b0, 16'sh0000},
            '{MODE_SAMPLE, 16'sh8000, 1'b0, 16'sh0000},
            '{MODE_SAMPLE, 16'sh7FFF, 1'b0, 16'sh0000},
            '{MODE_SAMPLE, 16'sh8000, 1'b0, 16'sh0000},
            '{MODE_SAMPLE, 16'sh00FF, 1'b0, 16'sh0000},
            '{MODE_SAMPLE, 16'shFF00, 1'b0, 16'sh0000},
            // flush before the first frame pads the whole window
            '{MODE_FLUSH,  16'sh0000, 1'b0, 16'sh0000},
            '{MODE_SAMPLE, 16'sh8000, 1'b0, 16'sh0000},
            '{MODE_FLUSH,  16'sh0000, 1'b0, 16'sh0000},
            '{MODE_FLUSH,  16'sh0000, 1'b0, 16'sh0000},
            '{MODE_FLUSH,  16'sh0000, 1'b0, 16'sh0000}
        };

        ahop_reg = AHOP_RST;
        shop_reg = SHOP_RST;
        build_hann_rom();
        clear_stream();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows at the reset hops; typed values replace the model where given
        foreach (dir_items[i]) begin
            send_item(dir_items[i].mode, dir_items[i].smp, sender_gap(), n);
            for (int k = pending_samples.size() - n; k < pending_samples.size(); k++) begin
                if (dir_items[i].known) pending_samples[k].sample_out = dir_items[i].known_out;
            end
        end

        // Random phases, each with its own hops, sample style and idling
        sent  = 0;
        phase = 0;
        while (sent < N_RAND) begin
            drain_outputs();
            case (phase)
                0: begin
                    ahop_new  = '0;
                    shop_data = '1;
                end
                1: begin
                    ahop_new  = '1;
                    shop_data = '0;
                end
                default: begin
                    case ($urandom_range(0, 9))
                        0:       ahop_new = '0;
                        1:       ahop_new = AHOP_W'(WIN);
                        2:       ahop_new = AHOP_W'($urandom_range(WIN + 1, 511));
                        3, 4:    ahop_new = AHOP_W'($urandom_range(1, 4));
                        5:       ahop_new = 9'd1;
                        6, 7:    ahop_new = AHOP_W'($urandom_range(1, 16));
                        8:       ahop_new = AHOP_RST;
                        default: ahop_new = AHOP_W'($urandom_range(1, WIN));
                    endcase
                    case ($urandom_range(0, 7))
                        0:       shop_data[SHOP_W-1:0] = '0;
                        1:       shop_data[SHOP_W-1:0] = 7'd1;
                        2:       shop_data[SHOP_W-1:0] = SHOP_RST;
                        3:       shop_data[SHOP_W-1:0] = SHOP_W'($urandom_range(65, 127));
                        default: shop_data[SHOP_W-1:0] = SHOP_W'($urandom_range(1, 64));
                    endcase
                    shop_data[CFG_DATA_W-1:SHOP_W] =
                        (CFG_DATA_W - SHOP_W)'($urandom_range(0, 3));
                end
            endcase
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_AHOP, CFG_DATA_W'(ahop_new));
                write_reg(CFG_SHOP, shop_data);
            end else begin
                write_reg(CFG_SHOP, shop_data);
                write_reg(CFG_AHOP, CFG_DATA_W'(ahop_new));
            end

            plen         = $urandom_range(15, 60);
            style        = $urandom_range(0, 3);
            flush_pct    = $urandom_range(0, 25);
            close_stream = $urandom_range(0, 2) != 0;
            tx_quiet     = $urandom_range(0, 3) == 0;
            rx_quiet     = $urandom_range(0, 3) == 0;

            for (int i = 0; i < plen && sent < N_RAND; i++) begin
                m = ($urandom_range(0, 99) < flush_pct) ? MODE_FLUSH : MODE_SAMPLE;
                send_item(m, pick_sample(style), sender_gap(), n);
                sent++;
                if ($urandom_range(0, 49) == 0) drain_outputs();
            end

            // Close the stream with a run of flushes where the run is short
            nres = (WIN + ahop_eff() - 1) / ahop_eff();
            if (close_stream && nres <= 8) begin
                while (flush_cnt != 0 || frame_started) begin
                    send_item(MODE_FLUSH, pick_sample(0), sender_gap(), n);
                    sent++;
                end
            end
            phase++;
        end

        drain_outputs();
        if (mismatch_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
